### hw/rtl/sld_pkg.sv
// shared types and constants for the sync/length packet deframer
package sld_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 9;

    // frame positions while a header is being read
    localparam logic [POS_W-1:0] POS_SYNC   = 9'd0;
    localparam logic [POS_W-1:0] POS_LENGTH = 9'd1;
    // header bytes ahead of the payload
    localparam logic [POS_W-1:0] HDR_LEN    = 9'd2;
    // header plus the resync byte, used when skipping a frame while hunting
    localparam logic [POS_W-1:0] SKIP_EXTRA = 9'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_length;
        logic              carries_byte;
        logic              last;
    } result_t;

endpackage

### hw/rtl/sld_frame_ctrl.sv
// frame tracking state and per-byte result logic
module sld_frame_ctrl
    import sld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx,
    input  logic [BYTE_W-1:0] sync_byte,
    output logic              has_result,
    output result_t           result
);

    logic              locked_reg;
    logic              locked_next;
    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;
    logic [BYTE_W-1:0] length_reg;
    logic [BYTE_W-1:0] length_next;

    logic             is_sync;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] idx_plus;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] len_ext;
    logic             fin;

    assign is_sync  = (rx == sync_byte);
    assign len_ext  = {1'b0, length_reg};
    assign idx      = position_reg - HDR_LEN;
    assign idx_plus = idx + 9'd1;
    assign pos_inc  = position_reg + 9'd1;
    assign fin      = (idx_plus >= len_ext);

    always_comb
    begin
        locked_next   = locked_reg;
        position_next = position_reg;
        length_next   = length_reg;
        has_result    = 1'b0;
        result        = '0;
        if (locked_reg)
        begin
            if (position_reg == POS_SYNC)
            begin
                if (is_sync)
                begin
                    position_next = POS_LENGTH;
                end
                else
                begin
                    locked_next   = 1'b0;
                    position_next = POS_SYNC;
                end
            end
            else if (position_reg == POS_LENGTH)
            begin
                length_next = rx;
                if (rx == '0)
                begin
                    // empty frame closes on its length byte
                    has_result          = 1'b1;
                    result.last         = 1'b1;
                    position_next       = POS_SYNC;
                end
                else
                begin
                    position_next = HDR_LEN;
                end
            end
            else
            begin
                has_result           = 1'b1;
                result.payload_byte  = rx;
                result.payload_index = idx[BYTE_W-1:0];
                result.frame_length  = length_reg;
                result.carries_byte  = 1'b1;
                result.last          = fin;
                position_next        = fin ? POS_SYNC : pos_inc;
            end
        end
        else
        begin
            if (position_reg == POS_SYNC)
            begin
                if (is_sync)
                begin
                    position_next = POS_LENGTH;
                end
            end
            else if (position_reg == POS_LENGTH)
            begin
                length_next   = rx;
                position_next = HDR_LEN;
            end
            else
            begin
                position_next = pos_inc;
                // payload skipped, this byte must be the next sync
                if (pos_inc >= (len_ext + SKIP_EXTRA))
                begin
                    if (is_sync)
                    begin
                        locked_next   = 1'b1;
                        position_next = POS_LENGTH;
                    end
                    else
                    begin
                        position_next = POS_SYNC;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg   <= 1'b0;
            position_reg <= '0;
            length_reg   <= '0;
        end
        else if (step)
        begin
            locked_reg   <= locked_next;
            position_reg <= position_next;
            length_reg   <= length_next;
        end
    end

endmodule

### hw/rtl/sld_out_reg.sv
// result register towards the downstream side
module sld_out_reg
    import sld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    input  logic    out_stall,
    output logic    out_valid,
    output logic    slot_free,
    output result_t result_q
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_q  = result_reg;

endmodule

### hw/rtl/sync_length_packet_deframer_core.sv
// top level: input register, sync byte register, frame logic and result register
// a request is held in the input register, its result then in the result register
// throughput: one byte per cycle, unless a byte with a result waits on out_stall
// a byte that gives no result passes through without needing the result register
// reset (rst_n low, asynchronous): hunting, position 0, length 0, sync byte 0, no
// requests held
module sync_length_packet_deframer_core
    import sld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] payload_byte,
    output logic [BYTE_W-1:0] payload_index,
    output logic [BYTE_W-1:0] frame_length,
    output logic              carries_byte,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BYTE_W-1:0] cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] rx_reg;
    logic [BYTE_W-1:0] sync_byte_reg;

    logic    accept;
    logic    advance;
    logic    has_result;
    logic    slot_free;
    result_t result;
    result_t result_q;

    assign cfg_ready = 1'b1;

    // a byte with no result moves on even while the result register is held
    assign advance  = in_valid_reg && (!has_result || slot_free);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sync_byte_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                sync_byte_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_reg <= rx_byte;
        end
    end

    sld_frame_ctrl u_frame_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx         (rx_reg),
        .sync_byte  (sync_byte_reg),
        .has_result (has_result),
        .result     (result)
    );

    sld_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .slot_free (slot_free),
        .result_q  (result_q)
    );

    assign payload_byte  = result_q.payload_byte;
    assign payload_index = result_q.payload_index;
    assign frame_length  = result_q.frame_length;
    assign carries_byte  = result_q.carries_byte;
    assign last          = result_q.last;

endmodule
